### design/ccm_pkg.sv
package ccm_pkg;

    // default reading width
    localparam int SAMPLE_BITS_DEF = 10;

    localparam int NUM_CLASSES = 5;
    localparam int NUM_STATS   = 6;
    localparam int CLASS_W     = 3;
    localparam int REG_IDX_W   = 3;

    // statistic slots
    localparam int STAT_MEAN  = 0;
    localparam int STAT_HI    = 1;
    localparam int STAT_LO    = 2;
    localparam int STAT_SPAN  = 3;
    localparam int STAT_ABOVE = 4;
    localparam int STAT_BELOW = 5;

    // class codes
    localparam logic [CLASS_W-1:0] CLS_RED   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_GREEN = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_BLUE  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_WHITE = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_BLACK = 3'd4;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CAL_RED   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CAL_GREEN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CAL_BLUE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CAL_WHITE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CAL_BLACK = 3'd5;

endpackage

### design/ccm_stats.sv
module ccm_stats #(
    parameter int SAMPLE_BITS = ccm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                              clk,
    input  logic [SAMPLE_BITS-1:0]                            rd_red,
    input  logic [SAMPLE_BITS-1:0]                            rd_green,
    input  logic [SAMPLE_BITS-1:0]                            rd_blue,
    output logic [ccm_pkg::NUM_STATS-1:0][SAMPLE_BITS-1:0]    stats
);

    localparam int SUM_W  = SAMPLE_BITS + 2;
    // floor(x/3) = (x * ceil(2^SHIFT/3)) >> SHIFT, exact for x < 2^SUM_W
    localparam int SHIFT  = SUM_W + 1;
    localparam int RECIP  = ((1 << SHIFT) + 2) / 3;
    localparam int PROD_W = SUM_W + SHIFT;

    logic [SUM_W-1:0]       sum_next, sum_reg;
    logic [SAMPLE_BITS-1:0] hi_next, hi_reg;
    logic [SAMPLE_BITS-1:0] lo_next, lo_reg;
    logic [SAMPLE_BITS-1:0] mx_rg, mn_rg;
    logic [PROD_W-1:0]      prod;
    logic [SAMPLE_BITS-1:0] mean;

    logic [ccm_pkg::NUM_STATS-1:0][SAMPLE_BITS-1:0] stats_next, stats_reg;

    // stage 1: sum, max, min
    always_comb
    begin
        sum_next = SUM_W'(rd_red) + SUM_W'(rd_green) + SUM_W'(rd_blue);
        mx_rg    = (rd_red > rd_green) ? rd_red : rd_green;
        mn_rg    = (rd_red < rd_green) ? rd_red : rd_green;
        hi_next  = (mx_rg > rd_blue) ? mx_rg : rd_blue;
        lo_next  = (mn_rg < rd_blue) ? mn_rg : rd_blue;
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
    end

    // stage 2: mean by reciprocal, then the differences
    always_comb
    begin
        prod = PROD_W'(sum_reg) * PROD_W'(SHIFT'(RECIP));
        mean = SAMPLE_BITS'(prod >> SHIFT);
        stats_next[ccm_pkg::STAT_MEAN]  = mean;
        stats_next[ccm_pkg::STAT_HI]    = hi_reg;
        stats_next[ccm_pkg::STAT_LO]    = lo_reg;
        stats_next[ccm_pkg::STAT_SPAN]  = hi_reg - lo_reg;
        stats_next[ccm_pkg::STAT_ABOVE] = hi_reg - mean;
        stats_next[ccm_pkg::STAT_BELOW] = mean - lo_reg;
    end

    always_ff @(posedge clk)
    begin
        stats_reg <= stats_next;
    end

    assign stats = stats_reg;

endmodule

### design/ccm_compare.sv
module ccm_compare #(
    parameter int SAMPLE_BITS = ccm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                           clk,
    input  logic [SAMPLE_BITS-1:0]                         tolerance,
    input  logic [ccm_pkg::NUM_STATS-1:0][SAMPLE_BITS-1:0] sample_stats,
    input  logic [ccm_pkg::NUM_CLASSES-1:0][ccm_pkg::NUM_STATS-1:0][SAMPLE_BITS-1:0]
                                                           class_stats,
    output logic [ccm_pkg::NUM_CLASSES-1:0]                match
);

    logic [ccm_pkg::NUM_CLASSES-1:0] match_next, match_reg;

    function automatic logic close_enough(input logic [SAMPLE_BITS-1:0] a,
                                          input logic [SAMPLE_BITS-1:0] b,
                                          input logic [SAMPLE_BITS-1:0] tol);
        logic [SAMPLE_BITS-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d < tol;
    endfunction

    always_comb
    begin
        for (int c = 0; c < ccm_pkg::NUM_CLASSES; c++)
        begin
            match_next[c] = 1'b1;
            for (int s = 0; s < ccm_pkg::NUM_STATS; s++)
            begin
                if (!close_enough(sample_stats[s], class_stats[c][s], tolerance))
                begin
                    match_next[c] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
    end

    assign match = match_reg;

endmodule

### design/color_class_matcher.sv
// color class matcher: takes one reading triple (red-, green- and blue-lit)
// per clock whenever start is high; busy is never raised, so every start is
// an accepted item. The result shows up on recognized and color_class from
// the winner-select register, marked by done for a single cycle. The receiver
// cannot stall the block and must take each result in the cycle that done is
// high. The pipeline is sum/max/min, mean and differences, class comparison,
// winner select, one register stage each, the first loaded at the accepting
// edge. The five class statistics are worked out continuously from the
// calibration registers through the same two-stage statistics pipe, so a
// register write takes effect for any item accepted in the next cycle on.
// Configuration is written through wr_en / wr_index / wr_data; indexes
// above the last register are ignored, as are bits above each register width.
module color_class_matcher #(
    parameter int SAMPLE_BITS = ccm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [SAMPLE_BITS-1:0]            reading_red_lit,
    input  logic [SAMPLE_BITS-1:0]            reading_green_lit,
    input  logic [SAMPLE_BITS-1:0]            reading_blue_lit,
    input  logic                              wr_en,
    input  logic [ccm_pkg::REG_IDX_W-1:0]     wr_index,
    input  logic [3*SAMPLE_BITS-1:0]          wr_data,
    output logic                              done,
    output logic                              recognized,
    output logic [ccm_pkg::CLASS_W-1:0]       color_class
);

    localparam int CAL_W = 3 * SAMPLE_BITS;

    // configuration
    logic [SAMPLE_BITS-1:0] tolerance_reg;
    logic [CAL_W-1:0]       cal_reg [ccm_pkg::NUM_CLASSES];

    // valid bits, one per stage
    logic valid_s1_reg, valid_s2_reg, valid_s3_reg;
    logic accept;

    logic [ccm_pkg::NUM_STATS-1:0][SAMPLE_BITS-1:0] sample_stats;
    logic [ccm_pkg::NUM_CLASSES-1:0][ccm_pkg::NUM_STATS-1:0][SAMPLE_BITS-1:0]
        class_stats;
    logic [ccm_pkg::NUM_CLASSES-1:0] match;

    // output stage
    logic                        done_reg;
    logic                        recognized_next, recognized_reg;
    logic [ccm_pkg::CLASS_W-1:0] color_class_next, color_class_reg;

    // block never holds off an item
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= '0;
            for (int c = 0; c < ccm_pkg::NUM_CLASSES; c++)
            begin
                cal_reg[c] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (wr_index)
                ccm_pkg::REG_TOLERANCE: tolerance_reg <= wr_data[SAMPLE_BITS-1:0];
                ccm_pkg::REG_CAL_RED:   cal_reg[ccm_pkg::CLS_RED]   <= wr_data;
                ccm_pkg::REG_CAL_GREEN: cal_reg[ccm_pkg::CLS_GREEN] <= wr_data;
                ccm_pkg::REG_CAL_BLUE:  cal_reg[ccm_pkg::CLS_BLUE]  <= wr_data;
                ccm_pkg::REG_CAL_WHITE: cal_reg[ccm_pkg::CLS_WHITE] <= wr_data;
                ccm_pkg::REG_CAL_BLACK: cal_reg[ccm_pkg::CLS_BLACK] <= wr_data;
                default: ;
            endcase
        end
    end

    // sample statistics, stages 1 and 2
    ccm_stats #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sample_stats (
        .clk      (clk),
        .rd_red   (reading_red_lit),
        .rd_green (reading_green_lit),
        .rd_blue  (reading_blue_lit),
        .stats    (sample_stats)
    );

    // class statistics, same latency as the sample path
    for (genvar g = 0; g < ccm_pkg::NUM_CLASSES; g++)
    begin : g_class
        ccm_stats #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_class_stats (
            .clk      (clk),
            .rd_red   (cal_reg[g][SAMPLE_BITS-1:0]),
            .rd_green (cal_reg[g][2*SAMPLE_BITS-1:SAMPLE_BITS]),
            .rd_blue  (cal_reg[g][3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
            .stats    (class_stats[g])
        );
    end

    // stage 3: per-class tolerance check
    ccm_compare #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_compare (
        .clk          (clk),
        .tolerance    (tolerance_reg),
        .sample_stats (sample_stats),
        .class_stats  (class_stats),
        .match        (match)
    );

    // stage 4: highest matching class wins
    always_comb
    begin
        recognized_next  = |match;
        color_class_next = ccm_pkg::CLS_RED;
        for (int c = 0; c < ccm_pkg::NUM_CLASSES; c++)
        begin
            if (match[c])
            begin
                color_class_next = ccm_pkg::CLASS_W'(c);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
            valid_s3_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= accept;
            valid_s2_reg <= valid_s1_reg;
            valid_s3_reg <= valid_s2_reg;
            done_reg     <= valid_s3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        recognized_reg  <= recognized_next;
        color_class_reg <= color_class_next;
    end

    assign done        = done_reg;
    assign recognized  = recognized_reg;
    assign color_class = color_class_reg;

    // every accepted item comes out with done raised
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("result missing four cycles after accept");

    // an unrecognized item reports the first class code
    a_no_match_code: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !recognized) |-> (color_class == ccm_pkg::CLS_RED))
        else $error("class code set without a match");

    // reported class is always a real class
    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (color_class <= ccm_pkg::CLS_BLACK))
        else $error("class code out of range");

endmodule
